// ===== design/geq_pkg.sv =====
// Shared types, constants and a lookup function for the gesture event qualifier.
package geq_pkg;

   localparam int SlotCount    = 8;
   localparam int SlotBits     = $clog2(SlotCount);
   localparam int GestureBits  = 8;
   localparam int NowBits      = 32;
   localparam int MsBits       = 16;
   localparam int RotBits      = 2;
   localparam int CmdBits      = 3;
   localparam int CsrIndexBits = 8;
   localparam int CsrDataBits  = 16;
   localparam int DefTimeBits  = 32;

   typedef enum logic [CsrIndexBits-1:0] {
      REG_ENABLE    = 8'd0,
      REG_ROTATION  = 8'd1,
      REG_COOLDOWN  = 8'd2,
      REG_DEBOUNCE  = 8'd3
   } csr_index_type;

   typedef enum logic [CmdBits-1:0] {
      CMD_VOL_UP   = 3'd0,
      CMD_VOL_DOWN = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_RIGHT    = 3'd3,
      CMD_FORWARD  = 3'd4,
      CMD_BACKWARD = 3'd5,
      CMD_CW       = 3'd6,
      CMD_CCW      = 3'd7
   } command_type;

   // Fixed gesture masks for the non-directional commands.
   localparam logic [GestureBits-1:0] MASK_FWD  = 8'h10;
   localparam logic [GestureBits-1:0] MASK_BACK = 8'h20;
   localparam logic [GestureBits-1:0] MASK_CW   = 8'h40;
   localparam logic [GestureBits-1:0] MASK_CCW  = 8'h80;

   typedef struct packed {
      logic [GestureBits-1:0] up;
      logic [GestureBits-1:0] down;
      logic [GestureBits-1:0] left;
      logic [GestureBits-1:0] right;
   } dir_masks_type;

   typedef struct packed {
      logic                nonzero;
      logic [SlotBits-1:0] slot;
      command_type         command;
   } decode_type;

   // Direction masks for each mounting angle: the sensor's raw direction bits are
   // rotated so that "up" always means up for the user.
   function automatic dir_masks_type dir_masks(input logic [RotBits-1:0] rot);
      dir_masks_type m;
      case (rot)
         2'd0:    m = '{up: 8'h08, down: 8'h04, left: 8'h01, right: 8'h02};
         2'd1:    m = '{up: 8'h01, down: 8'h02, left: 8'h04, right: 8'h08};
         2'd2:    m = '{up: 8'h04, down: 8'h08, left: 8'h02, right: 8'h01};
         2'd3:    m = '{up: 8'h02, down: 8'h01, left: 8'h08, right: 8'h04};
         default: m = '{up: 8'h08, down: 8'h04, left: 8'h01, right: 8'h02};
      endcase
      return m;
   endfunction

endpackage

// ===== design/gesture_event_qualifier.sv =====
// Top level of the gesture event qualifier: debounce, cooldown and command output.
//
// The qualifier takes one transfer per clock on the req_ channel while req_stall
// is low and delivers a command on the rsp_ channel: the input register takes the
// sample, then the decode, the cooldown and debounce compares and the timestamp
// update all happen combinationally between the input and result registers, so
// a new gesture sample can be taken every cycle. Each sample is a raw gesture
// flag byte and a free-running millisecond time. While enable is low every
// sample is dropped. The first sample seen while enabled after reset is dropped as
// well. A zero byte yields nothing. Otherwise the gesture is suppressed if less
// than cooldown_ms has passed since the last accepted gesture, or less than
// debounce_ms since the last accepted gesture in the slot of its lowest set bit;
// all time differences wrap at 2^TIME_BITS. An accepted gesture updates both
// timestamps and yields one command code. The result register and input register
// act as two independent stages, so req_stall is raised only when a sample waits
// in the input register while a finished command is held by rsp_stall. Registers
// are written through the csr_ channel, which is always ready; they should only be
// changed while no sample is in flight. Writes to unknown indexes are ignored.
module gesture_event_qualifier #(
   parameter int TIME_BITS = geq_pkg::DefTimeBits
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [geq_pkg::GestureBits-1:0]  req_gesture_bits,
   input  logic [geq_pkg::NowBits-1:0]      req_now_ms,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [geq_pkg::CmdBits-1:0]      rsp_command,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [geq_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [geq_pkg::CsrDataBits-1:0]  csr_wdata
);

   // Configuration registers.
   logic                          enable_ff;
   logic [geq_pkg::RotBits-1:0]   rotation_ff;
   logic [geq_pkg::MsBits-1:0]    cooldown_ff;
   logic [geq_pkg::MsBits-1:0]    debounce_ff;

   // Input stage.
   logic                              s1_valid_ff, s1_valid_in;
   logic [geq_pkg::GestureBits-1:0]   s1_bits_ff;
   logic [geq_pkg::NowBits-1:0]       s1_now_ff;

   // Qualifier state.
   logic                  first_pending_ff, first_pending_in;
   logic [TIME_BITS-1:0]  any_last_ff, any_last_in;
   logic [TIME_BITS-1:0]  slot_last_ff [geq_pkg::SlotCount];

   // Result stage.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [geq_pkg::CmdBits-1:0]   rsp_command_ff;

   logic                  out_free;
   logic                  s1_fire;
   logic                  emit;
   logic [TIME_BITS+geq_pkg::NowBits-1:0] now_ext;
   logic [TIME_BITS-1:0]  now_t;
   logic [TIME_BITS-1:0]  any_diff;
   logic [TIME_BITS-1:0]  slot_diff;
   logic                  cool_ok;
   logic                  deb_ok;
   geq_pkg::decode_type   dec;

   // Configuration port.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         rotation_ff <= '0;
         cooldown_ff <= '0;
         debounce_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (geq_pkg::csr_index_type'(csr_index))
            geq_pkg::REG_ENABLE:   enable_ff   <= csr_wdata[0];
            geq_pkg::REG_ROTATION: rotation_ff <= csr_wdata[geq_pkg::RotBits-1:0];
            geq_pkg::REG_COOLDOWN: cooldown_ff <= csr_wdata[geq_pkg::MsBits-1:0];
            geq_pkg::REG_DEBOUNCE: debounce_ff <= csr_wdata[geq_pkg::MsBits-1:0];
            default: ;
         endcase
      end
   end

   // Handshake. The input stage moves whenever the result register can take
   // whatever it produces.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign s1_fire   = s1_valid_ff && out_free;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_bits_ff <= req_gesture_bits;
         s1_now_ff  <= req_now_ms;
      end
   end

   geq_decode u_decode (
      .bits     (s1_bits_ff),
      .rotation (rotation_ff),
      .decode   (dec)
   );

   // Time is zero-extended or truncated to the timestamp width.
   assign now_ext   = {{TIME_BITS{1'b0}}, s1_now_ff};
   assign now_t     = now_ext[TIME_BITS-1:0];
   assign any_diff  = now_t - any_last_ff;
   assign slot_diff = now_t - slot_last_ff[dec.slot];
   assign cool_ok   = any_diff >= TIME_BITS'(cooldown_ff);
   assign deb_ok    = slot_diff >= TIME_BITS'(debounce_ff);

   assign emit = enable_ff && !first_pending_ff && dec.nonzero && cool_ok && deb_ok;

   always_comb begin
      first_pending_in = first_pending_ff;
      any_last_in      = any_last_ff;
      if (s1_fire && enable_ff) begin
         first_pending_in = 1'b0;
      end
      if (s1_fire && emit) begin
         any_last_in = now_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pending_ff <= 1'b1;
         any_last_ff      <= '0;
         for (int k = 0; k < geq_pkg::SlotCount; k++) begin
            slot_last_ff[k] <= '0;
         end
      end else begin
         first_pending_ff <= first_pending_in;
         any_last_ff      <= any_last_in;
         if (s1_fire && emit) begin
            slot_last_ff[dec.slot] <= now_t;
         end
      end
   end

   // Result register.
   assign rsp_valid_in = out_free ? (s1_fire && emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && emit) begin
         rsp_command_ff <= dec.command;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_command = rsp_command_ff;

   // A new command appears only right after a qualified gesture left the input stage.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_fire && emit))
      else $error("result appeared without a qualified gesture");

   // An emitted gesture stamps the global timestamp with its own time.
   a_stamp_update: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && emit) |=> (any_last_ff == $past(now_t)))
      else $error("timestamp not updated on an accepted gesture");

   // Once the first sample has been dropped, the flag never comes back.
   a_first_once: assert property (@(posedge clock) disable iff (reset)
      !first_pending_ff |=> !first_pending_ff)
      else $error("first-sample flag set again");

   // A disabled qualifier leaves its state untouched.
   a_disabled_quiet: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && !enable_ff) |=> ($stable(any_last_ff) && $stable(first_pending_ff)))
      else $error("state changed while disabled");

endmodule

// ===== design/geq_decode.sv =====
// Gesture byte decode: lowest set slot and the prioritized command code.
module geq_decode (
   input  logic [geq_pkg::GestureBits-1:0] bits,
   input  logic [geq_pkg::RotBits-1:0]     rotation,
   output geq_pkg::decode_type             decode
);

   geq_pkg::dir_masks_type masks;
   logic [geq_pkg::SlotBits-1:0] slot;

   assign masks = geq_pkg::dir_masks(rotation);

   // Lowest set bit picks the debounce slot.
   always_comb begin
      slot = '0;
      for (int k = geq_pkg::GestureBits - 1; k >= 0; k--) begin
         if (bits[k]) begin
            slot = geq_pkg::SlotBits'(k);
         end
      end
   end

   always_comb begin
      decode.nonzero = |bits;
      decode.slot    = slot;
      if ((bits & masks.up) != '0) begin
         decode.command = geq_pkg::CMD_VOL_UP;
      end else if ((bits & masks.down) != '0) begin
         decode.command = geq_pkg::CMD_VOL_DOWN;
      end else if ((bits & masks.left) != '0) begin
         decode.command = geq_pkg::CMD_STOP;
      end else if ((bits & masks.right) != '0) begin
         decode.command = geq_pkg::CMD_RIGHT;
      end else if ((bits & geq_pkg::MASK_FWD) != '0) begin
         decode.command = geq_pkg::CMD_FORWARD;
      end else if ((bits & geq_pkg::MASK_BACK) != '0) begin
         decode.command = geq_pkg::CMD_BACKWARD;
      end else if ((bits & geq_pkg::MASK_CW) != '0) begin
         decode.command = geq_pkg::CMD_CW;
      end else if ((bits & geq_pkg::MASK_CCW) != '0) begin
         decode.command = geq_pkg::CMD_CCW;
      end else begin
         decode.command = geq_pkg::CMD_VOL_UP;
      end
   end

endmodule

// ===== sim/tb_gesture_event_qualifier.sv =====
// Self-checking testbench for the gesture event qualifier, with directed and random samples.
`timescale 1ns / 100ps

module tb_gesture_event_qualifier;

   localparam int HALF_PERIOD    = 5;
   localparam int RESET_CYCLES   = 4;
   // Random samples to send over all phases; this only ends the stimulus.
   localparam int RANDOM_SAMPLES = 1650;
   // The result register follows the input register; the settle wait lets a sample
   // that yields nothing drain out of the pipeline.
   localparam int SETTLE_CYCLES  = 4;
   // Cycles in a row without any transfer before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 1000;
   // An index past the last register; a write there must change nothing.
   localparam logic [geq_pkg::CsrIndexBits-1:0] REG_UNUSED = 8'hFF;

   // Bit position of the up, down, left and right flags for each mounting angle.
   localparam logic [0:3][0:3][2:0] DIR_BIT = {
      {3'd3, 3'd2, 3'd0, 3'd1},
      {3'd0, 3'd1, 3'd2, 3'd3},
      {3'd2, 3'd3, 3'd1, 3'd0},
      {3'd1, 3'd0, 3'd3, 3'd2}
   };

   typedef struct packed {
      logic [geq_pkg::GestureBits-1:0] flags;
      logic [geq_pkg::NowBits-1:0]     now_ms;
   } gesture_sample_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [geq_pkg::GestureBits-1:0]  req_gesture_bits = '0;
   logic [geq_pkg::NowBits-1:0]      req_now_ms = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [geq_pkg::CmdBits-1:0]      rsp_command;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [geq_pkg::CsrIndexBits-1:0] csr_index = '0;
   logic [geq_pkg::CsrDataBits-1:0]  csr_wdata = '0;

   // Predictor copy of the registers and of the qualifier state.
   logic                             cfg_enable = 1'b0;
   logic [geq_pkg::RotBits-1:0]      cfg_rotation = '0;
   logic [geq_pkg::MsBits-1:0]       cfg_cooldown = '0;
   logic [geq_pkg::MsBits-1:0]       cfg_debounce = '0;
   logic                             first_sample_pending = 1'b1;
   logic [geq_pkg::NowBits-1:0]      last_any_ms = '0;
   logic [geq_pkg::NowBits-1:0]      last_slot_ms [geq_pkg::SlotCount];

   gesture_sample_type   pending_samples [$];
   geq_pkg::command_type expected_commands [$];

   // The driver counts the samples it has put on the bus, the monitor counts the
   // transfers; when they agree the sample on the bus has been taken.
   int driven_count = 0;
   int taken_count  = 0;
   int error_count  = 0;
   int idle_cycles  = 0;
   int burst_left   = 0;
   int gap_left     = 0;

   logic [geq_pkg::NowBits-1:0] sample_clock_ms = '0;
   logic [31:0]                 stall_pattern = '0;
   logic [4:0]                  stall_step = '0;

   always #HALF_PERIOD clock = ~clock;

   gesture_event_qualifier DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_gesture_bits (req_gesture_bits),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_command      (rsp_command),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   // Mirror a register write into the predictor. Unknown indexes fall through.
   function automatic void apply_reg_write(input logic [geq_pkg::CsrIndexBits-1:0] index,
                                           input logic [geq_pkg::CsrDataBits-1:0] value);
      case (index)
         geq_pkg::REG_ENABLE:   cfg_enable   = value[0];
         geq_pkg::REG_ROTATION: cfg_rotation = value[geq_pkg::RotBits-1:0];
         geq_pkg::REG_COOLDOWN: cfg_cooldown = value[geq_pkg::MsBits-1:0];
         geq_pkg::REG_DEBOUNCE: cfg_debounce = value[geq_pkg::MsBits-1:0];
         default: ;
      endcase
   endfunction

   // Run one sample through the debounce and cooldown rules. Returns 1 when the
   // gesture is accepted, with its command, and updates the timestamps then.
   function automatic bit qualify_gesture(input logic [geq_pkg::GestureBits-1:0] flags,
                                          input logic [geq_pkg::NowBits-1:0] now_ms,
                                          output geq_pkg::command_type cmd);
      logic [geq_pkg::GestureBits-1:0] order [8];
      logic [geq_pkg::NowBits-1:0]     since_any;
      logic [geq_pkg::NowBits-1:0]     since_slot;
      int                              slot;
      int                              k;
      cmd = geq_pkg::CMD_VOL_UP;
      // A disabled qualifier drops everything and keeps the first-sample flag.
      if (!cfg_enable) return 1'b0;
      // The first sample after reset is thrown away whatever it holds.
      if (first_sample_pending) begin
         first_sample_pending = 1'b0;
         return 1'b0;
      end
      if (flags == '0) return 1'b0;
      slot = 0;
      for (k = geq_pkg::GestureBits - 1; k >= 0; k--) begin
         if (flags[k]) slot = k;
      end
      // Elapsed times wrap at 32 bits; a zero interval never suppresses.
      since_any  = now_ms - last_any_ms;
      since_slot = now_ms - last_slot_ms[slot];
      if (since_any < geq_pkg::NowBits'(cfg_cooldown)) return 1'b0;
      if (since_slot < geq_pkg::NowBits'(cfg_debounce)) return 1'b0;
      last_any_ms        = now_ms;
      last_slot_ms[slot] = now_ms;
      // Priority runs up, down, left, right (moved by the mounting angle), then the
      // fixed forward, back, clockwise and counterclockwise flags.
      for (k = 0; k < 4; k++) begin
         order[k] = geq_pkg::GestureBits'(1) << DIR_BIT[cfg_rotation][k];
      end
      order[4] = geq_pkg::MASK_FWD;
      order[5] = geq_pkg::MASK_BACK;
      order[6] = geq_pkg::MASK_CW;
      order[7] = geq_pkg::MASK_CCW;
      for (k = 7; k >= 0; k--) begin
         if ((flags & order[k]) != '0) cmd = geq_pkg::command_type'(k);
      end
      return 1'b1;
   endfunction

   // Monitor: everything is sampled at the rising edge, where the inputs have been
   // stable since the falling edge. Register writes, sample transfers and result
   // transfers are all observed here, and the watchdog runs on the same edges.
   always @(posedge clock) begin : monitor
      geq_pkg::command_type want;
      bit                   moved;
      moved = 1'b0;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            apply_reg_write(csr_index, csr_wdata);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_commands.size() == 0) begin
               error_count++;
               $display("%0t: command expected none, actual %0d", $time, rsp_command);
            end else begin
               want = expected_commands.pop_front();
               if (rsp_command !== want) begin
                  error_count++;
                  $display("%0t: command expected %0d (%s), actual %0d",
                           $time, want, want.name(), rsp_command);
               end
            end
         end
         if (req_valid && !req_stall) begin
            moved = 1'b1;
            taken_count++;
            if (qualify_gesture(req_gesture_bits, req_now_ms, want))
               expected_commands.push_back(want);
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
               $display("gesture_event_qualifier verification failed");
               $finish;
            end
         end
      end
   end

   // Driver: works in bursts of random length separated by random gaps. A sample
   // stays on the bus unchanged until its transfer; req_valid gets exactly one
   // nonblocking assignment per falling edge so it never glitches between samples.
   always @(negedge clock) begin : sender
      gesture_sample_type next_item;
      logic               next_valid;
      next_valid = req_valid;
      if (!reset) begin
         if (req_valid && taken_count == driven_count) next_valid = 1'b0;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_samples.size() != 0) begin
               next_item = pending_samples.pop_front();
               req_gesture_bits <= next_item.flags;
               req_now_ms       <= next_item.now_ms;
               next_valid = 1'b1;
               driven_count++;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // Now and then a long burst with no gap gives full-rate stretches.
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 150)
                                                           : $urandom_range(0, 20);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
      req_valid <= next_valid;
   end

   // Receiver: stalls from a 32-bit pattern that is redrawn each time it runs out,
   // ranging from no stall at all to stalling most of the time.
   always @(negedge clock) begin : receiver
      if (stall_step == '0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = '0;
            1:       stall_pattern = $urandom & $urandom;
            2:       stall_pattern = $urandom;
            default: stall_pattern = $urandom | $urandom;
         endcase
      end
      rsp_stall <= stall_pattern[stall_step];
      stall_step = stall_step + 1'b1;
   end

   task automatic write_reg(input logic [geq_pkg::CsrIndexBits-1:0] index,
                            input logic [geq_pkg::CsrDataBits-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_sample(input logic [geq_pkg::GestureBits-1:0] flags,
                             input logic [geq_pkg::NowBits-1:0] now_ms);
      pending_samples.push_back('{flags: flags, now_ms: now_ms});
   endtask

   // Wait until every queued sample has been transferred and every predicted
   // command has arrived, then let the pipeline drain samples that yield nothing.
   task automatic wait_settled();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || driven_count != taken_count ||
             expected_commands.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic int pick_interval();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 16'hFFFF;
         2:       return $urandom_range(1, 16);
         default: return $urandom_range(1, 3000);
      endcase
   endfunction

   // Random samples on a running millisecond clock. Most steps are drawn around the
   // cooldown and debounce intervals so that both checks land on either side of
   // their limits; a few steps are arbitrary jumps, which also carry the clock
   // across the 32-bit wrap.
   task automatic add_random_samples(input int count, input int cooldown, input int debounce);
      logic [geq_pkg::NowBits-1:0]     step_ms;
      logic [geq_pkg::GestureBits-1:0] flags;
      int                              near_ms;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: step_ms = $urandom_range(0, cooldown + 2);
            4, 5, 6:    step_ms = $urandom_range(0, debounce / 4 + 2);
            7: begin
               near_ms = ($urandom_range(0, 1) ? cooldown : debounce) - $urandom_range(0, 1);
               step_ms = (near_ms < 0) ? '0 : geq_pkg::NowBits'(near_ms);
            end
            8:       step_ms = '0;
            default: step_ms = $urandom;
         endcase
         sample_clock_ms = sample_clock_ms + step_ms;
         case ($urandom_range(0, 9))
            0:          flags = '0;
            1, 2, 3, 4: flags = geq_pkg::GestureBits'(1) << $urandom_range(0, 7);
            default:    flags = geq_pkg::GestureBits'($urandom_range(0, 255));
         endcase
         add_sample(flags, sample_clock_ms);
      end
   endtask

   initial begin : stimulus
      int   cooldown;
      int   debounce;
      int   count;
      int   split;
      int   random_total;
      logic enable_bit;
      foreach (last_slot_ms[s]) last_slot_ms[s] = '0;
      random_total = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Out of reset the qualifier is disabled, so these must vanish without
      // consuming the first-sample discard.
      add_sample(8'h01, 32'd100);
      add_sample(8'hFF, 32'hFFFF_FFFF);
      wait_settled();

      write_reg(REG_UNUSED, 16'hFFFF);
      write_reg(geq_pkg::REG_ENABLE, 16'd1);
      write_reg(geq_pkg::REG_ROTATION, 16'd0);
      write_reg(geq_pkg::REG_COOLDOWN, 16'd0);
      write_reg(geq_pkg::REG_DEBOUNCE, 16'd0);

      // First sample is dropped, a zero byte gives nothing, then every flag alone
      // and all flags at once, with no interval limits in the way.
      add_sample(8'h08, 32'd5);
      add_sample(8'h00, 32'd6);
      for (int b = 0; b < geq_pkg::GestureBits; b++)
         add_sample(geq_pkg::GestureBits'(1) << b, 32'd7 + b);
      add_sample(8'hFF, 32'hFFFF_FFFF);
      wait_settled();

      // Largest mounting angle: each direction flag maps to a different command.
      write_reg(geq_pkg::REG_ROTATION, 16'd3);
      for (int b = 0; b < 4; b++) add_sample(geq_pkg::GestureBits'(1) << b, 32'd0 + b);
      wait_settled();

      // Cooldown across the time wrap, then the largest debounce interval.
      write_reg(geq_pkg::REG_ROTATION, 16'd2);
      write_reg(geq_pkg::REG_COOLDOWN, 16'h0020);
      write_reg(geq_pkg::REG_DEBOUNCE, 16'hFFFF);
      add_sample(8'h10, 32'hFFFF_FFF0);
      add_sample(8'h20, 32'h0000_0005);
      add_sample(8'h20, 32'h0000_0010);
      add_sample(8'h80, 32'h0000_0030);
      wait_settled();

      // Random phases, each with its own register setting. Some phases stop the
      // sender partway until every predicted command has come back.
      while (random_total < RANDOM_SAMPLES) begin
         enable_bit = ($urandom_range(0, 7) != 0);
         cooldown   = pick_interval();
         debounce   = pick_interval();
         write_reg(geq_pkg::REG_ENABLE, geq_pkg::CsrDataBits'(enable_bit));
         write_reg(geq_pkg::REG_ROTATION, geq_pkg::CsrDataBits'($urandom_range(0, 3)));
         write_reg(geq_pkg::REG_COOLDOWN, geq_pkg::CsrDataBits'(cooldown));
         write_reg(geq_pkg::REG_DEBOUNCE, geq_pkg::CsrDataBits'(debounce));
         sample_clock_ms = ($urandom_range(0, 3) == 0) ?
                           32'hFFFF_FFFF - $urandom_range(0, 70000) : $urandom;
         count = $urandom_range(60, 200);
         split = ($urandom_range(0, 1) == 0) ? count : $urandom_range(1, count - 1);
         add_random_samples(split, cooldown, debounce);
         if (split < count) begin
            wait_settled();
            add_random_samples(count - split, cooldown, debounce);
         end
         random_total += count;
         wait_settled();
      end

      wait_settled();
      if (expected_commands.size() != 0) begin
         error_count++;
         $display("%0t: %0d commands expected, none delivered", $time,
                  expected_commands.size());
      end
      if (error_count == 0) begin
         $display("gesture_event_qualifier verification clean");
      end else begin
         $display("gesture_event_qualifier verification failed");
      end
      $finish;
   end

endmodule
